### hdl/smj_pkg.sv
// shared types and constants for the shooter mode and jam reverse core
`default_nettype none

package smj_pkg;

	typedef enum logic [1:0] {
		MODE_STOP  = 2'd0,
		MODE_READY = 2'd1,
		MODE_FIRE  = 2'd2
	} mode_t;

	localparam logic [1:0] SW_OTHER = 2'd0;
	localparam logic [1:0] SW_UP    = 2'd1;
	localparam logic [1:0] SW_MID   = 2'd2;
	localparam logic [1:0] SW_DOWN  = 2'd3;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LONG    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_LONG   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TICKS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_TICKS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SPEED   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_SPEED = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FRICTION_SPD  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_FRICTION_RDY  = 3'd7;

	typedef struct packed {
		logic [15:0]        press_long_ticks;
		logic [15:0]        switch_long_ticks;
		logic [15:0]        block_ticks;
		logic [15:0]        reverse_ticks;
		logic [14:0]        block_speed_rpm;
		logic signed [15:0] trigger_speed_rpm;
		logic [14:0]        friction_speed_rpm;
		logic [14:0]        friction_ready_rpm;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         switch_pos;
		logic               mouse_left;
		logic               gimbal_stop;
		logic signed [15:0] trigger_rpm;
		logic signed [15:0] right_wheel_rpm;
	} item_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] trigger_set_rpm;
		logic signed [15:0] left_wheel_set_rpm;
		logic signed [15:0] right_wheel_set_rpm;
		logic               full_current_limit;
		logic               laser_en;
		logic               reversing;
	} result_t;

endpackage

`default_nettype wire

### hdl/shooter_mode_and_jam_reverse_core.sv
// top level of the shooter mode and jam reverse core
`default_nettype none

// Launcher mode controller with trigger jam reversal. One transaction on the
// input channel is one control tick; it yields exactly one transaction on the
// output channel. A tick is taken into an input register, worked in a single
// combinational step that updates the mode, hold and jam state, and lands in
// the result register, so the block sustains one tick per clock while results
// are taken. One tick can wait in the input register while a finished result
// waits to be taken; only then does the input stall. Configuration writes take
// effect on the next clock and should be made only while idle.

module shooter_mode_and_jam_reverse_core
	import smj_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            switch_pos,
	input  wire logic                  mouse_left,
	input  wire logic                  gimbal_stop,
	input  wire logic signed [15:0]    trigger_rpm,
	input  wire logic signed [15:0]    right_wheel_rpm,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 mode,
	output logic signed [15:0]         trigger_set_rpm,
	output logic signed [15:0]         left_wheel_set_rpm,
	output logic signed [15:0]         right_wheel_set_rpm,
	output logic                       full_current_limit,
	output logic                       laser_en,
	output logic                       reversing
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;
	logic    step_en;

	assign advance  = !out_valid_q || out_ready;
	assign step_en  = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	smj_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.switch_pos      <= switch_pos;
			item_s1.mouse_left      <= mouse_left;
			item_s1.gimbal_stop     <= gimbal_stop;
			item_s1.trigger_rpm     <= trigger_rpm;
			item_s1.right_wheel_rpm <= right_wheel_rpm;
		end
	end

	smj_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= res;
		end
	end

	assign out_valid           = out_valid_q;
	assign mode                = res_q.mode;
	assign trigger_set_rpm     = res_q.trigger_set_rpm;
	assign left_wheel_set_rpm  = res_q.left_wheel_set_rpm;
	assign right_wheel_set_rpm = res_q.right_wheel_set_rpm;
	assign full_current_limit  = res_q.full_current_limit;
	assign laser_en            = res_q.laser_en;
	assign reversing           = res_q.reversing;

	// reverse drive only while firing
	a_rev_fire: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.reversing |-> res_q.mode == MODE_FIRE)
		else $error("reversing outside fire mode");

	// laser follows mode
	a_laser: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.laser_en == (res_q.mode != MODE_STOP))
		else $error("laser does not match mode");

	// wheels run in opposite directions
	a_wheels: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.right_wheel_set_rpm == -res_q.left_wheel_set_rpm)
		else $error("wheel setpoints not opposite");

	// stall on input only when both stages are full and the output is blocked
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled with free stage");

	// a transaction in the input stage moves on when the output frees
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> out_valid_q)
		else $error("transaction lost between stages");

endmodule

`default_nettype wire

### hdl/smj_cfg.sv
// configuration register file
`default_nettype none

module smj_cfg
	import smj_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_long_ticks   <= 16'd400;
			cfg_q.switch_long_ticks  <= 16'd2000;
			cfg_q.block_ticks        <= 16'd700;
			cfg_q.reverse_ticks      <= 16'd500;
			cfg_q.block_speed_rpm    <= 15'd100;
			cfg_q.trigger_speed_rpm  <= 16'sd2000;
			cfg_q.friction_speed_rpm <= 15'd6000;
			cfg_q.friction_ready_rpm <= 15'd4800;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_PRESS_LONG:    cfg_q.press_long_ticks   <= cfg_data;
				CFG_SWITCH_LONG:   cfg_q.switch_long_ticks  <= cfg_data;
				CFG_BLOCK_TICKS:   cfg_q.block_ticks        <= cfg_data;
				CFG_REVERSE_TICKS: cfg_q.reverse_ticks      <= cfg_data;
				CFG_BLOCK_SPEED:   cfg_q.block_speed_rpm    <= cfg_data[14:0];
				CFG_TRIGGER_SPEED: cfg_q.trigger_speed_rpm  <= $signed(cfg_data);
				CFG_FRICTION_SPD:  cfg_q.friction_speed_rpm <= cfg_data[14:0];
				CFG_FRICTION_RDY:  cfg_q.friction_ready_rpm <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hdl/smj_step.sv
// mode choice, hold and jam counters and setpoint logic for one tick
`default_nettype none

module smj_step
	import smj_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  step_en,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output result_t    res
);

	mode_t       mode_q, mode_n;
	logic        latched_q, seen_q;
	logic [15:0] btn_hold_q, btn_hold_n;
	logic [15:0] sw_hold_q, sw_hold_n;
	logic        running_q, running_n;
	logic        limit_q, limit_n;
	logic [15:0] jam_q, jam_n;
	logic [15:0] rev_cnt_q, rev_cnt_n;

	logic               rev;
	logic [16:0]        mag;
	logic signed [15:0] trig_set;
	logic signed [15:0] wheel;
	logic signed [15:0] neg_trig;

	always_comb begin
		mode_n = mode_q;
		case (item.switch_pos)
			SW_UP:   mode_n = MODE_FIRE;
			SW_MID:  mode_n = (latched_q && !seen_q) ? MODE_FIRE : MODE_READY;
			SW_DOWN: mode_n = MODE_STOP;
			default: ;
		endcase
		if (btn_hold_q == cfg.press_long_ticks || sw_hold_q == cfg.switch_long_ticks)
			mode_n = MODE_FIRE;
		if (item.gimbal_stop)
			mode_n = MODE_STOP;
	end

	always_comb begin
		if (!item.mouse_left)
			btn_hold_n = '0;
		else if (btn_hold_q < cfg.press_long_ticks)
			btn_hold_n = btn_hold_q + 16'd1;
		else
			btn_hold_n = btn_hold_q;

		if (mode_n == MODE_STOP || item.switch_pos != SW_UP)
			sw_hold_n = '0;
		else if (sw_hold_q < cfg.switch_long_ticks)
			sw_hold_n = sw_hold_q + 16'd1;
		else
			sw_hold_n = sw_hold_q;
	end

	always_comb begin
		mag = item.trigger_rpm[15] ? (17'd0 - {1'b1, item.trigger_rpm})
			: {1'b0, item.trigger_rpm};
		neg_trig = (cfg.trigger_speed_rpm == -16'sd32768) ? 16'sd32767
			: -cfg.trigger_speed_rpm;
		running_n = running_q;
		limit_n   = limit_q;
		jam_n     = jam_q;
		rev_cnt_n = rev_cnt_q;
		rev       = 1'b0;
		trig_set  = '0;
		case (mode_n)
			MODE_STOP: begin
				running_n = 1'b0;
				limit_n   = 1'b0;
			end
			MODE_READY: begin
				running_n = 1'b1;
				if (item.right_wheel_rpm > $signed({1'b0, cfg.friction_ready_rpm}))
					limit_n = 1'b1;
			end
			default: begin
				rev      = jam_q >= cfg.block_ticks;
				trig_set = rev ? neg_trig : cfg.trigger_speed_rpm;
				if (mag < {2'b00, cfg.block_speed_rpm} && jam_q < cfg.block_ticks) begin
					jam_n     = jam_q + 16'd1;
					rev_cnt_n = '0;
				end else if (jam_q == cfg.block_ticks && rev_cnt_q < cfg.reverse_ticks) begin
					rev_cnt_n = rev_cnt_q + 16'd1;
				end else begin
					jam_n = '0;
				end
			end
		endcase
		wheel = running_n ? $signed({1'b0, cfg.friction_speed_rpm}) : 16'sd0;
	end

	always_comb begin
		res.mode                = mode_n;
		res.trigger_set_rpm     = trig_set;
		res.left_wheel_set_rpm  = wheel;
		res.right_wheel_set_rpm = -wheel;
		res.full_current_limit  = limit_n;
		res.laser_en            = mode_n != MODE_STOP;
		res.reversing           = rev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_STOP;
			latched_q   <= 1'b0;
			seen_q      <= 1'b0;
			btn_hold_q  <= '0;
			sw_hold_q   <= '0;
			running_q   <= 1'b0;
			limit_q     <= 1'b0;
			jam_q       <= '0;
			rev_cnt_q   <= '0;
		end else if (step_en) begin
			mode_q      <= mode_n;
			latched_q   <= item.mouse_left;
			seen_q      <= latched_q;
			btn_hold_q  <= btn_hold_n;
			sw_hold_q   <= sw_hold_n;
			running_q   <= running_n;
			limit_q     <= limit_n;
			jam_q       <= jam_n;
			rev_cnt_q   <= rev_cnt_n;
		end
	end

endmodule

`default_nettype wire

### test/launcher_tick_checker.sv
// checker for the shooter core: tracks registers, predicts each tick result and compares
module launcher_tick_checker
	import smj_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [1:0]            switch_pos,
	input  logic                  mouse_left,
	input  logic                  gimbal_stop,
	input  logic signed [15:0]    trigger_rpm,
	input  logic signed [15:0]    right_wheel_rpm,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [1:0]            mode,
	input  logic signed [15:0]    trigger_set_rpm,
	input  logic signed [15:0]    left_wheel_set_rpm,
	input  logic signed [15:0]    right_wheel_set_rpm,
	input  logic                  full_current_limit,
	input  logic                  laser_en,
	input  logic                  reversing,
	output int                    mismatch_count,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t      regs;
	mode_t     mode_q;
	bit        latched, seen, seen_prev, armed, running, full_lim;
	logic [15:0] press_hold, switch_hold, jam_ticks, reverse_ticks_done;
	result_t   expected_results[$];

	function automatic result_t next_tick_result(input item_t t);
		result_t r;
		int      trig_set;
		int      mag;
		int      wheel;
		bit      rev;
		seen_prev = seen;
		seen = latched;
		case (t.switch_pos)
			SW_UP: mode_q = MODE_FIRE;
			SW_MID: begin
				mode_q = (seen && !seen_prev) ? MODE_FIRE : MODE_READY;
			end
			SW_DOWN: begin
				mode_q = MODE_STOP;
				armed = 1'b0;
			end
			default: ;
		endcase
		if (press_hold == regs.press_long_ticks || switch_hold == regs.switch_long_ticks) begin
			mode_q = MODE_FIRE;
			armed = 1'b0;
		end
		if (t.gimbal_stop)
			mode_q = MODE_STOP;

		latched = t.mouse_left;
		if (t.mouse_left) begin
			if (press_hold < regs.press_long_ticks)
				press_hold = press_hold + 16'd1;
		end else begin
			press_hold = '0;
		end
		if (mode_q != MODE_STOP && t.switch_pos == SW_UP) begin
			if (switch_hold < regs.switch_long_ticks)
				switch_hold = switch_hold + 16'd1;
		end else begin
			switch_hold = '0;
		end

		trig_set = 0;
		rev = 1'b0;
		case (mode_q)
			MODE_STOP: begin
				running = 1'b0;
				full_lim = 1'b0;
			end
			MODE_READY: begin
				if (int'(t.right_wheel_rpm) > int'(regs.friction_ready_rpm))
					full_lim = 1'b1;
				running = 1'b1;
			end
			default: begin
				armed = 1'b1;
				rev = jam_ticks >= regs.block_ticks;
				trig_set = int'(regs.trigger_speed_rpm);
				if (rev)
					trig_set = (-trig_set > 32767) ? 32767 : -trig_set;
				mag = int'(t.trigger_rpm);
				if (mag < 0)
					mag = -mag;
				if (mag < int'(regs.block_speed_rpm) && jam_ticks < regs.block_ticks) begin
					jam_ticks = jam_ticks + 16'd1;
					reverse_ticks_done = '0;
				end else if (jam_ticks == regs.block_ticks
						&& reverse_ticks_done < regs.reverse_ticks) begin
					reverse_ticks_done = reverse_ticks_done + 16'd1;
				end else begin
					jam_ticks = '0;
				end
			end
		endcase
		wheel = running ? int'(regs.friction_speed_rpm) : 0;

		r.mode = mode_q;
		r.trigger_set_rpm = 16'(trig_set);
		r.left_wheel_set_rpm = 16'(wheel);
		r.right_wheel_set_rpm = 16'(-wheel);
		r.full_current_limit = full_lim;
		r.laser_en = (mode_q != MODE_STOP);
		r.reversing = rev;
		return r;
	endfunction

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t   tick;
		result_t exp_r;
		if (!arst_n) begin
			regs.press_long_ticks = 16'd400;
			regs.switch_long_ticks = 16'd2000;
			regs.block_ticks = 16'd700;
			regs.reverse_ticks = 16'd500;
			regs.block_speed_rpm = 15'd100;
			regs.trigger_speed_rpm = 16'sd2000;
			regs.friction_speed_rpm = 15'd6000;
			regs.friction_ready_rpm = 15'd4800;
			mode_q = MODE_STOP;
			{latched, seen, seen_prev, armed, running, full_lim} = '0;
			press_hold = '0;
			switch_hold = '0;
			jam_ticks = '0;
			reverse_ticks_done = '0;
			expected_results.delete();
			mismatch_count = 0;
			outstanding = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_PRESS_LONG:    regs.press_long_ticks = cfg_data;
					CFG_SWITCH_LONG:   regs.switch_long_ticks = cfg_data;
					CFG_BLOCK_TICKS:   regs.block_ticks = cfg_data;
					CFG_REVERSE_TICKS: regs.reverse_ticks = cfg_data;
					CFG_BLOCK_SPEED:   regs.block_speed_rpm = cfg_data[14:0];
					CFG_TRIGGER_SPEED: regs.trigger_speed_rpm = cfg_data;
					CFG_FRICTION_SPD:  regs.friction_speed_rpm = cfg_data[14:0];
					CFG_FRICTION_RDY:  regs.friction_ready_rpm = cfg_data[14:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: result transaction with nothing expected", $time);
				end else begin
					exp_r = expected_results.pop_front();
					check_field("mode", int'(exp_r.mode), int'(mode));
					check_field("trigger_set_rpm", int'(exp_r.trigger_set_rpm),
						int'(trigger_set_rpm));
					check_field("left_wheel_set_rpm", int'(exp_r.left_wheel_set_rpm),
						int'(left_wheel_set_rpm));
					check_field("right_wheel_set_rpm", int'(exp_r.right_wheel_set_rpm),
						int'(right_wheel_set_rpm));
					check_field("full_current_limit", int'(exp_r.full_current_limit),
						int'(full_current_limit));
					check_field("laser_en", int'(exp_r.laser_en), int'(laser_en));
					check_field("reversing", int'(exp_r.reversing), int'(reversing));
				end
			end
			if (in_valid && in_ready) begin
				tick.switch_pos = switch_pos;
				tick.mouse_left = mouse_left;
				tick.gimbal_stop = gimbal_stop;
				tick.trigger_rpm = trigger_rpm;
				tick.right_wheel_rpm = right_wheel_rpm;
				expected_results.push_back(next_tick_result(tick));
			end
			outstanding = expected_results.size();
		end
	end

endmodule

### test/testbench.sv
// top of the shooter core testbench: clock, reset, register settings, tick stimulus, verdict
module testbench;
	import smj_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_OFF_CYCLES = 250;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            switch_pos;
	logic                  mouse_left;
	logic                  gimbal_stop;
	logic signed [15:0]    trigger_rpm;
	logic signed [15:0]    right_wheel_rpm;
	logic                  out_valid;
	logic                  out_ready;
	logic [1:0]            mode;
	logic signed [15:0]    trigger_set_rpm;
	logic signed [15:0]    left_wheel_set_rpm;
	logic signed [15:0]    right_wheel_set_rpm;
	logic                  full_current_limit;
	logic                  laser_en;
	logic                  reversing;

	int   mismatch_count;
	int   outstanding;
	int   idle_cycles;
	bit   idle_on;
	bit   rx_hold_req;
	cfg_t cur_cfg;
	logic [1:0] sw_cur;
	int   sw_left;
	bit   mouse_cur;
	int   mouse_left_ticks;

	shooter_mode_and_jam_reverse_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.switch_pos(switch_pos),
		.mouse_left(mouse_left),
		.gimbal_stop(gimbal_stop),
		.trigger_rpm(trigger_rpm),
		.right_wheel_rpm(right_wheel_rpm),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mode(mode),
		.trigger_set_rpm(trigger_set_rpm),
		.left_wheel_set_rpm(left_wheel_set_rpm),
		.right_wheel_set_rpm(right_wheel_set_rpm),
		.full_current_limit(full_current_limit),
		.laser_en(laser_en),
		.reversing(reversing)
	);

	launcher_tick_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.switch_pos(switch_pos),
		.mouse_left(mouse_left),
		.gimbal_stop(gimbal_stop),
		.trigger_rpm(trigger_rpm),
		.right_wheel_rpm(right_wheel_rpm),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mode(mode),
		.trigger_set_rpm(trigger_set_rpm),
		.left_wheel_set_rpm(left_wheel_set_rpm),
		.right_wheel_set_rpm(right_wheel_set_rpm),
		.full_current_limit(full_current_limit),
		.laser_en(laser_en),
		.reversing(reversing),
		.mismatch_count(mismatch_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stalls while idle_on is set, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				out_ready <= 1'b0;
				for (int k = 0; k < HOLD_OFF_CYCLES; k++)
					@(negedge clk);
				rx_hold_req = 1'b0;
			end
			out_ready <= (!idle_on || $urandom_range(99) >= 38);
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int clip16(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// called and returns at a falling edge; valid stays up after the transaction
	task automatic send_tick(input logic [1:0] sw, input bit ml, input bit gs,
			input int tr, input int rw);
		while (idle_on && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		switch_pos <= sw;
		mouse_left <= ml;
		gimbal_stop <= gs;
		trigger_rpm <= 16'(tr);
		right_wheel_rpm <= 16'(rw);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_regs(input int p, input int s, input int b, input int r,
			input int bs, input int ts, input int fs, input int fr);
		logic [15:0] vals [8];
		vals[CFG_PRESS_LONG] = 16'(p);
		vals[CFG_SWITCH_LONG] = 16'(s);
		vals[CFG_BLOCK_TICKS] = 16'(b);
		vals[CFG_REVERSE_TICKS] = 16'(r);
		vals[CFG_BLOCK_SPEED] = 16'(bs);
		vals[CFG_TRIGGER_SPEED] = 16'(ts);
		vals[CFG_FRICTION_SPD] = 16'(fs);
		vals[CFG_FRICTION_RDY] = 16'(fr);
		cur_cfg.press_long_ticks = vals[CFG_PRESS_LONG];
		cur_cfg.switch_long_ticks = vals[CFG_SWITCH_LONG];
		cur_cfg.block_ticks = vals[CFG_BLOCK_TICKS];
		cur_cfg.reverse_ticks = vals[CFG_REVERSE_TICKS];
		cur_cfg.block_speed_rpm = vals[CFG_BLOCK_SPEED][14:0];
		cur_cfg.trigger_speed_rpm = vals[CFG_TRIGGER_SPEED];
		cur_cfg.friction_speed_rpm = vals[CFG_FRICTION_SPD][14:0];
		cur_cfg.friction_ready_rpm = vals[CFG_FRICTION_RDY][14:0];
		for (int i = 0; i < 8; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			@(negedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// mostly held switch and button runs with speeds near the thresholds, some noise
	task automatic send_random(input int count, input int hold_at);
		int  bs;
		int  pick;
		int  tr;
		int  rw;
		for (int n = 0; n < count; n++) begin
			if (n == hold_at)
				rx_hold_req = 1'b1;
			if ($urandom_range(99) < 10) begin
				send_tick(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
					int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768);
			end else begin
				if (sw_left == 0) begin
					pick = $urandom_range(99);
					sw_cur = (pick < 35) ? SW_UP : (pick < 70) ? SW_MID :
						(pick < 85) ? SW_DOWN : SW_OTHER;
					sw_left = $urandom_range(1, 40);
				end
				sw_left--;
				if (mouse_left_ticks == 0) begin
					mouse_cur = 1'($urandom_range(1));
					mouse_left_ticks = mouse_cur ? $urandom_range(1, 30) : $urandom_range(1, 12);
				end
				mouse_left_ticks--;
				bs = int'(cur_cfg.block_speed_rpm);
				pick = $urandom_range(99);
				if (pick < 45)
					tr = int'($urandom_range(0, 2 * bs + 2)) - bs - 1;
				else if (pick < 55)
					tr = ($urandom_range(1) != 0) ? -32768 : 32767;
				else
					tr = int'($urandom_range(65535)) - 32768;
				if ($urandom_range(1) != 0)
					rw = int'(cur_cfg.friction_ready_rpm) + int'($urandom_range(40)) - 20;
				else
					rw = int'($urandom_range(65535)) - 32768;
				send_tick(sw_cur, mouse_cur, $urandom_range(99) < 4, clip16(tr), clip16(rw));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		switch_pos = SW_OTHER;
		mouse_left = 1'b0;
		gimbal_stop = 1'b0;
		trigger_rpm = '0;
		right_wheel_rpm = '0;
		idle_on = 1'b1;
		rx_hold_req = 1'b0;
		sw_cur = SW_OTHER;
		sw_left = 0;
		mouse_cur = 1'b0;
		mouse_left_ticks = 0;
		cur_cfg = '{16'd400, 16'd2000, 16'd700, 16'd500, 15'd100, 16'sd2000,
			15'd6000, 15'd4800};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed ticks at the reset register values
		send_tick(SW_DOWN, 1'b0, 1'b0, 0, 0);
		send_tick(SW_OTHER, 1'b0, 1'b0, 32767, -32768);
		send_tick(SW_MID, 1'b0, 1'b0, -32768, 4801);
		send_tick(SW_MID, 1'b1, 1'b0, 0, 32767);
		send_tick(SW_MID, 1'b1, 1'b0, 0, 0);
		send_tick(SW_MID, 1'b0, 1'b0, 0, 0);
		send_tick(SW_MID, 1'b0, 1'b0, 0, 0);
		send_tick(SW_UP, 1'b0, 1'b0, 50, 0);
		send_tick(SW_UP, 1'b0, 1'b0, -32768, -1);
		send_tick(SW_UP, 1'b1, 1'b1, 0, 0);
		send_tick(SW_OTHER, 1'b0, 1'b0, 0, 0);
		send_tick(SW_UP, 1'b0, 1'b0, 99, 0);
		send_tick(SW_OTHER, 1'b0, 1'b0, 100, 0);
		send_tick(SW_DOWN, 1'b0, 1'b0, -101, 0);
		send_tick(SW_MID, 1'b0, 1'b0, 0, 4800);
		send_tick(SW_MID, 1'b0, 1'b0, -1, -1);
		send_tick(SW_MID, 1'b1, 1'b0, 32767, 32767);
		send_tick(SW_UP, 1'b1, 1'b0, -99, 0);
		send_tick(SW_UP, 1'b1, 1'b0, -100, 0);
		send_tick(SW_DOWN, 1'b0, 1'b1, 0, 0);
		send_random(150, -1);
		drain();

		set_regs(5, 8, 4, 6, 100, 2000, 6000, 4800);
		send_random(190, 60);
		drain();
		set_regs(0, 0, 0, 0, 0, 0, 0, 0);
		send_random(190, -1);
		drain();
		idle_on = 1'b0;
		set_regs(65535, 65535, 65535, 65535, 32767, 32767, 32767, 32767);
		send_random(190, -1);
		drain();
		idle_on = 1'b1;
		set_regs(1, 1, 2, 1, 32767, -32768, 1234, 0);
		send_random(190, -1);
		drain();
		set_regs(12, 30, 20, 40, 500, -1500, 7000, 5000);
		send_random(190, -1);
		drain();
		// lowered jam limit while a jam count may sit above it
		set_regs(3, 3, 3, 2, 300, 1, 20000, 100);
		send_random(190, -1);
		drain();
		for (int ph = 0; ph < 2; ph++) begin
			set_regs($urandom_range(0, 24), $urandom_range(0, 40), $urandom_range(0, 20),
				$urandom_range(0, 20), $urandom_range(0, 32767), int'($urandom_range(65535)) - 32768,
				$urandom_range(0, 32767), $urandom_range(0, 32767));
			send_random(190, -1);
			drain();
		end

		if (mismatch_count == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
